@@ design/fpw_pkg.sv @@
// Package for the four-level page table walker.
// Holds the controller state type, operation codes and page-table bit positions.
// Depends on nothing.
`default_nettype none

package fpw_pkg;

  // Operation codes carried by in_op
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_XLATE = 2'd1;
  localparam logic [1:0] OP_UNMAP = 2'd2;

  // Page size codes carried by out_pg_size
  localparam logic [1:0] SIZE_4K = 2'd0;
  localparam logic [1:0] SIZE_2M = 2'd1;
  localparam logic [1:0] SIZE_1G = 2'd2;

  // Walk levels, top table first
  localparam logic [1:0] LVL_PML4 = 2'd3;
  localparam logic [1:0] LVL_PDPT = 2'd2;
  localparam logic [1:0] LVL_PD   = 2'd1;
  localparam logic [1:0] LVL_PT   = 2'd0;

  // Entry bits and address widths
  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;
  localparam int PA_W        = 52;
  localparam int VA_W        = 48;
  localparam int WORD_ADDR_W = 49;
  localparam int IDX_W       = 9;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } fpw_state_t;

  // Pick the 9-bit table index of a virtual address for one level
  function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LVL_PML4: idx = va[47:39];
      LVL_PDPT: idx = va[38:30];
      LVL_PD:   idx = va[29:21];
      default:  idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage : fpw_pkg

`default_nettype wire

@@ design/four_level_page_table_walker_unit.sv @@
// Four-level page table walker: table store, walk controller and result register.
// Depends on fpw_pkg for the state type, op codes and index selection.
`default_nettype none

// Keeps STORE_WORDS 64-bit page-table words in one synchronous RAM (one write
// and one registered read port). After reset the block runs a clearing pass
// over all STORE_WORDS words, one word per cycle, with in_ready low; cfg
// writes are taken during it. A table write is accepted, then its result is
// handed off from the final state. Translate and unmap read one table level
// at a time, because each level's address comes from the previous entry
// read out of the RAM: four levels for a 4 KiB page, three for 2 MiB and
// two for 1 GiB, fewer on an early miss or a rejected item. An unmap
// clears the leaf in the same cycle it is checked. One item is in flight at a
// time; the result register holds a finished result while the next item is
// accepted, and a walk waits in its final state only if that register is
// still full.
module four_level_page_table_walker_unit #(
  parameter int STORE_WORDS = 4096
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // configuration
  input  wire                    cfg_wr_en,
  input  wire [fpw_pkg::PA_W-1:0] cfg_wr_data,
  // input channel
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire [1:0]              in_op,
  input  wire [fpw_pkg::PA_W-1:0] in_root,
  input  wire [fpw_pkg::VA_W-1:0] in_virt_addr,
  input  wire [fpw_pkg::PA_W-1:0] in_mem_addr,
  input  wire [63:0]             in_entry_data,
  // result channel
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic                   out_ok,
  output logic [fpw_pkg::PA_W-1:0] out_phys_addr,
  output logic [11:0]            out_leaf_flags,
  output logic [1:0]             out_pg_size
);
  import fpw_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);
  localparam logic [AW-1:0] CLR_LAST = AW'(STORE_WORDS - 1);
  localparam logic [WORD_ADDR_W-1:0] STORE_LIM = WORD_ADDR_W'(STORE_WORDS);

  // Table store
  logic [63:0]   table_mem [STORE_WORDS];
  logic [63:0]   rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  // Control and walk registers
  fpw_state_t        state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [PA_W-1:0]   kroot_r;
  logic [1:0]        lvl_r, lvl_nxt;
  logic              unmap_r, unmap_nxt;
  logic [VA_W-1:0]   va_r, va_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;

  // Pending result
  logic              res_ok_r, res_ok_nxt;
  logic [PA_W-1:0]   res_pa_r, res_pa_nxt;
  logic [11:0]       res_flags_r, res_flags_nxt;
  logic [1:0]        res_size_r, res_size_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [PA_W-1:0]   out_pa_r, out_pa_nxt;
  logic [11:0]       out_flags_r, out_flags_nxt;
  logic [1:0]        out_size_r, out_size_nxt;

  // Address and decode helpers
  logic                   in_fire;
  logic                   op_walk;
  logic [PA_W-1:0]        base_in;
  logic [WORD_ADDR_W-1:0] start_w;
  logic [WORD_ADDR_W-1:0] wr_w;
  logic                   wr_ok;
  logic                   walk_start;
  logic [63:0]            ent;
  logic                   ent_present;
  logic                   ent_large;
  logic [1:0]             lvl_dn;
  logic [WORD_ADDR_W-1:0] next_w;
  logic                   walk_more;
  logic                   out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign op_walk  = (in_op == OP_XLATE) || (in_op == OP_UNMAP);

  // Select the top table and form the first word address
  assign base_in = (in_root == '0) ? kroot_r : in_root;
  assign start_w = {base_in[PA_W-1:12], va_index(in_virt_addr, LVL_PML4)};
  assign wr_w    = in_mem_addr[PA_W-1:3];
  assign wr_ok   = (wr_w < STORE_LIM);
  assign walk_start = op_walk && (start_w < STORE_LIM) &&
                      !((in_op == OP_UNMAP) && (in_virt_addr[11:0] != 12'd0));

  // Decode the entry returned by the store and the next word address
  assign ent         = rd_q;
  assign ent_present = ent[BIT_PRESENT];
  assign ent_large   = ent[BIT_LARGE];
  assign lvl_dn      = 2'(lvl_r - 2'd1);
  assign next_w      = {ent[PA_W-1:12], va_index(va_r, lvl_dn)};
  assign walk_more   = ent_present && (next_w < STORE_LIM) &&
                       ((lvl_r == LVL_PML4) ||
                        (((lvl_r == LVL_PDPT) || (lvl_r == LVL_PD)) && !ent_large));
  assign out_free    = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = walk_start ? ST_WALK : ST_FIN;
      end
      ST_WALK: begin
        if (!walk_more) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Store accesses, walk registers and results
  always_comb begin
    mem_we        = 1'b0;
    mem_waddr     = slot_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = next_w[AW-1:0];
    clr_nxt       = clr_r;
    lvl_nxt       = lvl_r;
    unmap_nxt     = unmap_r;
    va_nxt        = va_r;
    slot_nxt      = slot_r;
    res_ok_nxt    = res_ok_r;
    res_pa_nxt    = res_pa_r;
    res_flags_nxt = res_flags_r;
    res_size_nxt  = res_size_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_pa_nxt    = out_pa_r;
    out_flags_nxt = out_flags_r;
    out_size_nxt  = out_size_r;
    case (state_r)
      ST_CLEAR: begin
        // Zero one word per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = AW'(clr_r + 1'b1);
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_ok_nxt    = 1'b0;
          res_pa_nxt    = '0;
          res_flags_nxt = '0;
          res_size_nxt  = SIZE_4K;
          unmap_nxt     = (in_op == OP_UNMAP);
          va_nxt        = in_virt_addr;
          lvl_nxt       = LVL_PML4;
          case (in_op)
            OP_WRITE: begin
              res_ok_nxt = wr_ok;
              mem_we     = wr_ok;
              mem_waddr  = wr_w[AW-1:0];
              mem_wdata  = in_entry_data;
            end
            OP_XLATE, OP_UNMAP: begin
              // Issue the top-level read
              mem_re    = walk_start;
              mem_raddr = start_w[AW-1:0];
              slot_nxt  = start_w[AW-1:0];
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (walk_more) begin
          // Descend one level
          mem_re   = 1'b1;
          slot_nxt = next_w[AW-1:0];
          lvl_nxt  = lvl_dn;
        end else if (ent_present) begin
          case (lvl_r)
            LVL_PDPT: begin
              if (ent_large && !unmap_r) begin
                res_ok_nxt    = 1'b1;
                res_pa_nxt    = {ent[PA_W-1:30], va_r[29:0]};
                res_flags_nxt = ent[11:0];
                res_size_nxt  = SIZE_1G;
              end
            end
            LVL_PD: begin
              if (ent_large && !unmap_r) begin
                res_ok_nxt    = 1'b1;
                res_pa_nxt    = {ent[PA_W-1:21], va_r[20:0]};
                res_flags_nxt = ent[11:0];
                res_size_nxt  = SIZE_2M;
              end
            end
            LVL_PT: begin
              res_ok_nxt    = 1'b1;
              res_flags_nxt = ent[11:0];
              res_size_nxt  = SIZE_4K;
              if (unmap_r) begin
                // Clear the leaf and return its frame
                res_pa_nxt = {ent[PA_W-1:12], 12'd0};
                mem_we     = 1'b1;
                mem_waddr  = slot_r;
              end else begin
                res_pa_nxt = {ent[PA_W-1:12], va_r[11:0]};
              end
            end
            default: ;
          endcase
        end
      end
      ST_FIN: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_pa_nxt    = res_pa_r;
          out_flags_nxt = res_flags_r;
          out_size_nxt  = res_size_r;
        end
      end
      default: ;
    endcase
  end

  // Table store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) table_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= table_mem[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      kroot_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) kroot_r <= cfg_wr_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lvl_r       <= lvl_nxt;
    unmap_r     <= unmap_nxt;
    va_r        <= va_nxt;
    slot_r      <= slot_nxt;
    res_ok_r    <= res_ok_nxt;
    res_pa_r    <= res_pa_nxt;
    res_flags_r <= res_flags_nxt;
    res_size_r  <= res_size_nxt;
    out_ok_r    <= out_ok_nxt;
    out_pa_r    <= out_pa_nxt;
    out_flags_r <= out_flags_nxt;
    out_size_r  <= out_size_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_phys_addr  = out_pa_r;
  assign out_leaf_flags = out_flags_r;
  assign out_pg_size    = out_size_r;

`ifndef SYNTHESIS
  // The store is written during a walk only to clear a 4 KiB leaf on unmap
  a_walk_write_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r == ST_WALK)) |-> (unmap_r && (lvl_r == LVL_PT)))
    else $error("store written during walk outside an unmap leaf");

  // An accepted item goes straight to a walk or to the result handoff
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> ((state_r == ST_WALK) || (state_r == ST_FIN)))
    else $error("accepted item did not start a walk or finish");

  // A failed item carries an all-zero result
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |->
      ((out_phys_addr == '0) && (out_leaf_flags == '0) && (out_pg_size == SIZE_4K)))
    else $error("failed result carries nonzero fields");
`endif

endmodule : four_level_page_table_walker_unit

`default_nettype wire
